[hw/rtl/spring_damper_rk2_step_defines.svh]
// assertion macros shared by the spring damper rk2 step rtl
`ifndef SPRING_DAMPER_RK2_STEP_DEFINES_SVH
`define SPRING_DAMPER_RK2_STEP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDRK2_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdrk2 check failed");

// next-cycle implication, checked outside reset
`define SDRK2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdrk2 check failed");

`endif

[hw/rtl/sdrk2_pkg.sv]
// types, constants and arithmetic helpers for the spring damper rk2 step
package sdrk2_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int UCFG_WIDTH = 31;
    localparam int STEP_WIDTH = 5;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [DATA_WIDTH:0]   wide_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [STEP_WIDTH-1:0] LAST_STEP = 5'd16;

    typedef struct packed {
        word_t force_x;
        word_t force_y;
        word_t force_z;
    } in_item_t;

    typedef struct packed {
        word_t new_position;
        word_t new_velocity;
        word_t disp_x;
        word_t disp_y;
        word_t disp_z;
        word_t axial_force;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_TIME_STEP    = 3'd0,
        REG_INVERSE_MASS = 3'd1,
        REG_DAMPING      = 3'd2,
        REG_STIFFNESS    = 3'd3,
        REG_FORCE_GAIN   = 3'd4,
        REG_AXIS_X       = 3'd5,
        REG_AXIS_Y       = 3'd6,
        REG_AXIS_Z       = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        SRC_FX, SRC_FY, SRC_FZ,
        SRC_AX, SRC_AY, SRC_AZ,
        SRC_GAIN, SRC_H, SRC_TS,
        SRC_DAMP, SRC_STIFF, SRC_IMASS,
        SRC_POS, SRC_VEL, SRC_ACC,
        SRC_T, SRC_VM, SRC_YM, SRC_FORCE
    } src_t;

    typedef enum logic [1:0] {
        CMB_SET,
        CMB_ADD,
        CMB_SUB
    } cmb_t;

    typedef enum logic [3:0] {
        DST_ACC, DST_FORCE, DST_YM, DST_T, DST_VM,
        DST_POS, DST_VEL, DST_DX, DST_DY, DST_DZ
    } dst_t;

    typedef struct packed {
        src_t a_sel;
        src_t b_sel;
        cmb_t cmb;
        src_t base_sel;
        dst_t dst;
    } uop_t;

    // microcode: dst = sat(a * b), or sat(base (+|-) sat(a * b))
    function automatic uop_t uop_at(input logic [STEP_WIDTH-1:0] step);
        uop_t u;
        unique case (step)
            5'd0:    u = '{SRC_FX,    SRC_AX,    CMB_SET, SRC_ACC,   DST_ACC};
            5'd1:    u = '{SRC_FY,    SRC_AY,    CMB_ADD, SRC_ACC,   DST_ACC};
            5'd2:    u = '{SRC_FZ,    SRC_AZ,    CMB_ADD, SRC_ACC,   DST_ACC};
            5'd3:    u = '{SRC_ACC,   SRC_GAIN,  CMB_SET, SRC_ACC,   DST_FORCE};
            5'd4:    u = '{SRC_H,     SRC_VEL,   CMB_ADD, SRC_POS,   DST_YM};
            5'd5:    u = '{SRC_DAMP,  SRC_VEL,   CMB_SUB, SRC_FORCE, DST_ACC};
            5'd6:    u = '{SRC_STIFF, SRC_POS,   CMB_SUB, SRC_ACC,   DST_ACC};
            5'd7:    u = '{SRC_ACC,   SRC_IMASS, CMB_SET, SRC_ACC,   DST_T};
            5'd8:    u = '{SRC_H,     SRC_T,     CMB_ADD, SRC_VEL,   DST_VM};
            5'd9:    u = '{SRC_TS,    SRC_VM,    CMB_ADD, SRC_POS,   DST_POS};
            5'd10:   u = '{SRC_DAMP,  SRC_VM,    CMB_SUB, SRC_FORCE, DST_ACC};
            5'd11:   u = '{SRC_STIFF, SRC_YM,    CMB_SUB, SRC_ACC,   DST_ACC};
            5'd12:   u = '{SRC_ACC,   SRC_IMASS, CMB_SET, SRC_ACC,   DST_T};
            5'd13:   u = '{SRC_TS,    SRC_T,     CMB_ADD, SRC_VEL,   DST_VEL};
            5'd14:   u = '{SRC_POS,   SRC_AX,    CMB_SET, SRC_ACC,   DST_DX};
            5'd15:   u = '{SRC_POS,   SRC_AY,    CMB_SET, SRC_ACC,   DST_DY};
            5'd16:   u = '{SRC_POS,   SRC_AZ,    CMB_SET, SRC_ACC,   DST_DZ};
            default: u = '{SRC_FX,    SRC_AX,    CMB_SET, SRC_ACC,   DST_ACC};
        endcase
        return u;
    endfunction

    // product >> FRAC_BITS (floor), saturated to the word range
    function automatic word_t sat_prod(input prod_t p);
        prod_t                           shifted;
        logic [PROD_WIDTH-DATA_WIDTH:0]  upper;
        word_t                           r;
        shifted = p >>> FRAC_BITS;
        upper   = shifted[PROD_WIDTH-1:DATA_WIDTH-1];
        if ((&upper) || !(|upper))
            r = shifted[DATA_WIDTH-1:0];
        else if (p[PROD_WIDTH-1])
            r = WORD_MIN;
        else
            r = WORD_MAX;
        return r;
    endfunction

    function automatic word_t sat_wide(input wide_t s);
        word_t r;
        if (s[DATA_WIDTH] == s[DATA_WIDTH-1])
            r = s[DATA_WIDTH-1:0];
        else if (s[DATA_WIDTH])
            r = WORD_MIN;
        else
            r = WORD_MAX;
        return r;
    endfunction

endpackage

[hw/rtl/spring_damper_rk2_step.sv]
// spring damper rk2 step: top level with sequencer and shared multiplier
//
// usage notes
// - input channel (in_valid / in_stall / in_data) takes one request holding a
//   3d force; in_stall stays high from acceptance until the result has moved
//   into the output register
// - output channel (out_valid / out_stall / out_data) gives position,
//   velocity, displacement vector and axial force after each step
// - every request runs 17 multiply-saturate-accumulate operations through one
//   32x32 multiplier; each passes through a multiply state and an accumulate state
// - one request at a time: a new request is taken only once the previous
//   result has moved into the output register, as the multiplier is shared
// - a stalled output holds its result; the next request is still accepted and
//   computed, and waits in the final state until the output register frees up
// - reset (rst_n low) clears position and velocity and loads the default
//   register values; configuration is written through cfg_wr_en / cfg_index /
//   cfg_data while no request is in flight
`include "spring_damper_rk2_step_defines.svh"

module spring_damper_rk2_step
    import sdrk2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  cfg_index_t cfg_index,
    input  word_t      cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    localparam logic [UCFG_WIDTH-1:0] TS_RESET    = 31'd655;
    localparam logic [UCFG_WIDTH-1:0] IMASS_RESET = 31'd65536;
    localparam word_t                 ONE_Q       = 32'sd65536;

    // configuration
    logic [UCFG_WIDTH-1:0] ts_reg, imass_reg, damp_reg, stiff_reg;
    word_t                 gain_reg, axis_x_reg, axis_y_reg, axis_z_reg;

    // sequencer
    state_t                state_reg, state_next;
    logic [STEP_WIDTH-1:0] step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  load_out;
    logic                  out_free;
    logic                  accept;

    // datapath
    word_t fx_reg, fy_reg, fz_reg;
    word_t pos_reg, vel_reg;
    word_t acc_reg, force_reg, ym_reg, t_reg, vm_reg;
    word_t dx_reg, dy_reg, dz_reg;
    prod_t prod_reg;
    out_item_t out_reg;

    uop_t  uop;
    word_t a_word, b_word, base_word;
    word_t prod_sat;
    wide_t sum_wide;
    word_t result;

    function automatic word_t pick(input src_t s);
        word_t r;
        case (s)
            SRC_FX:    r = fx_reg;
            SRC_FY:    r = fy_reg;
            SRC_FZ:    r = fz_reg;
            SRC_AX:    r = axis_x_reg;
            SRC_AY:    r = axis_y_reg;
            SRC_AZ:    r = axis_z_reg;
            SRC_GAIN:  r = gain_reg;
            SRC_H:     r = {2'b00, ts_reg[UCFG_WIDTH-1:1]};   // dt * 0.5, floor
            SRC_TS:    r = {1'b0, ts_reg};
            SRC_DAMP:  r = {1'b0, damp_reg};
            SRC_STIFF: r = {1'b0, stiff_reg};
            SRC_IMASS: r = {1'b0, imass_reg};
            SRC_POS:   r = pos_reg;
            SRC_VEL:   r = vel_reg;
            SRC_ACC:   r = acc_reg;
            SRC_T:     r = t_reg;
            SRC_VM:    r = vm_reg;
            SRC_YM:    r = ym_reg;
            SRC_FORCE: r = force_reg;
            default:   r = '0;
        endcase
        return r;
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                    step_next  = '0;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ST_DONE;
                else
                begin
                    state_next = ST_MUL;
                    step_next  = step_reg + 5'd1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg     <= TS_RESET;
            imass_reg  <= IMASS_RESET;
            damp_reg   <= '0;
            stiff_reg  <= '0;
            gain_reg   <= ONE_Q;
            axis_x_reg <= ONE_Q;
            axis_y_reg <= '0;
            axis_z_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:    ts_reg     <= cfg_data[UCFG_WIDTH-1:0];
                REG_INVERSE_MASS: imass_reg  <= cfg_data[UCFG_WIDTH-1:0];
                REG_DAMPING:      damp_reg   <= cfg_data[UCFG_WIDTH-1:0];
                REG_STIFFNESS:    stiff_reg  <= cfg_data[UCFG_WIDTH-1:0];
                REG_FORCE_GAIN:   gain_reg   <= cfg_data;
                REG_AXIS_X:       axis_x_reg <= cfg_data;
                REG_AXIS_Y:       axis_y_reg <= cfg_data;
                REG_AXIS_Z:       axis_z_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // shared multiply and saturating accumulate
    always_comb
    begin
        uop       = uop_at(step_reg);
        a_word    = pick(uop.a_sel);
        b_word    = pick(uop.b_sel);
        base_word = pick(uop.base_sel);
        prod_sat  = sat_prod(prod_reg);
        if (uop.cmb == CMB_SUB)
            sum_wide = {base_word[DATA_WIDTH-1], base_word}
                     - {prod_sat[DATA_WIDTH-1], prod_sat};
        else
            sum_wide = {base_word[DATA_WIDTH-1], base_word}
                     + {prod_sat[DATA_WIDTH-1], prod_sat};
        case (uop.cmb) inside
            CMB_SET:          result = prod_sat;
            CMB_ADD, CMB_SUB: result = sat_wide(sum_wide);
            default:          result = prod_sat;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fx_reg <= in_data.force_x;
            fy_reg <= in_data.force_y;
            fz_reg <= in_data.force_z;
        end
        if (state_reg == ST_MUL)
            prod_reg <= a_word * b_word;
        if (state_reg == ST_ACC)
        begin
            case (uop.dst)
                DST_ACC:   acc_reg   <= result;
                DST_FORCE: force_reg <= result;
                DST_YM:    ym_reg    <= result;
                DST_T:     t_reg     <= result;
                DST_VM:    vm_reg    <= result;
                DST_DX:    dx_reg    <= result;
                DST_DY:    dy_reg    <= result;
                DST_DZ:    dz_reg    <= result;
                default:   ;
            endcase
        end
        if (load_out)
        begin
            out_reg.new_position <= pos_reg;
            out_reg.new_velocity <= vel_reg;
            out_reg.disp_x       <= dx_reg;
            out_reg.disp_y       <= dy_reg;
            out_reg.disp_z       <= dz_reg;
            out_reg.axial_force  <= force_reg;
        end
    end

    // state: position and velocity are updated in place by the microcode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
        end
        else if (state_reg == ST_ACC)
        begin
            if (uop.dst == DST_POS)
                pos_reg <= result;
            if (uop.dst == DST_VEL)
                vel_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SDRK2_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept,
        (state_reg == ST_MUL) && (step_reg == '0))
    `SDRK2_ASSERT_NOW(a_step_in_range, clk, rst_n, state_reg != ST_IDLE,
        step_reg <= LAST_STEP)
    `SDRK2_ASSERT_NEXT(a_last_to_done, clk, rst_n,
        (state_reg == ST_ACC) && (step_reg == LAST_STEP), state_reg == ST_DONE)
    `SDRK2_ASSERT_NEXT(a_done_delivers, clk, rst_n,
        (state_reg == ST_DONE) && !out_stall, out_valid && (state_reg == ST_IDLE))

endmodule

[tb/testbench.sv]
// testbench for spring_damper_rk2_step: force steps checked against a q16.16 rk2 predictor
`timescale 1ns / 100ps

module testbench
    import sdrk2_pkg::*;
();

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     HOLDOFF_CYCLES = 400;
    localparam int     BLOCK_ITEMS    = 50;
    localparam int     DRAIN_CYCLES   = 40;
    localparam longint Q_MAX          = 64'sd2147483647;
    localparam longint Q_MIN          = -64'sd2147483648;
    localparam longint Q_HALF         = 64'sd1 <<< (FRAC_BITS - 1);

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    word_t      cfg_data;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int holdoff_len    = 0;
    int holdoff_done   = 0;
    int idle_cycles    = 0;
    int mismatches     = 0;

    word_t     cfg_shadow [8];
    longint    coef [8];
    longint    spring_pos;
    longint    spring_vel;
    out_item_t pending_steps [$];

    spring_damper_rk2_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------- q16.16 predictor ----------------

    function automatic longint clip(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // arithmetic shift of the exact product floors toward minus infinity
    function automatic longint qmul(input longint a, input longint b);
        return clip((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint qadd(input longint a, input longint b);
        return clip(a + b);
    endfunction

    function automatic longint qsub(input longint a, input longint b);
        return clip(a - b);
    endfunction

    function automatic void apply_register(input cfg_index_t idx, input word_t v);
        case (idx) inside
            REG_TIME_STEP, REG_INVERSE_MASS, REG_DAMPING, REG_STIFFNESS:
                coef[idx] = longint'({1'b0, v[UCFG_WIDTH-1:0]});
            default:
                coef[idx] = longint'(v);
        endcase
    endfunction

    function automatic out_item_t advance_spring(input in_item_t f);
        longint    h;
        longint    dot;
        longint    push;
        longint    ym;
        longint    acc;
        longint    vm;
        longint    ny;
        longint    nv;
        out_item_t r;
        h    = qmul(coef[REG_TIME_STEP], Q_HALF);
        dot  = qadd(qadd(qmul(f.force_x, coef[REG_AXIS_X]), qmul(f.force_y, coef[REG_AXIS_Y])),
                    qmul(f.force_z, coef[REG_AXIS_Z]));
        push = qmul(dot, coef[REG_FORCE_GAIN]);
        // midpoint estimate
        ym   = qadd(spring_pos, qmul(h, spring_vel));
        acc  = qsub(qsub(push, qmul(coef[REG_DAMPING], spring_vel)),
                    qmul(coef[REG_STIFFNESS], spring_pos));
        vm   = qadd(spring_vel, qmul(h, qmul(acc, coef[REG_INVERSE_MASS])));
        // full step from midpoint slopes
        ny   = qadd(spring_pos, qmul(coef[REG_TIME_STEP], vm));
        acc  = qsub(qsub(push, qmul(coef[REG_DAMPING], vm)), qmul(coef[REG_STIFFNESS], ym));
        nv   = qadd(spring_vel, qmul(coef[REG_TIME_STEP], qmul(acc, coef[REG_INVERSE_MASS])));
        spring_pos = ny;
        spring_vel = nv;
        r.new_position = word_t'(ny);
        r.new_velocity = word_t'(nv);
        r.disp_x       = word_t'(qmul(ny, coef[REG_AXIS_X]));
        r.disp_y       = word_t'(qmul(ny, coef[REG_AXIS_Y]));
        r.disp_z       = word_t'(qmul(ny, coef[REG_AXIS_Z]));
        r.axial_force  = word_t'(push);
        return r;
    endfunction

    // ---------------- stimulus generation ----------------

    function automatic word_t rail_word();
        word_t r;
        case ($urandom_range(4))
            0:       r = '0;
            1:       r = WORD_MAX;
            2:       r = WORD_MIN;
            3:       r = -32'sd1;
            default: r = 32'sd1;
        endcase
        return r;
    endfunction

    function automatic word_t pick_force();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return word_t'($urandom_range(2097152)) - word_t'(1048576);
        if (roll < 85)
            return word_t'($urandom);
        return rail_word();
    endfunction

    function automatic in_item_t random_force();
        in_item_t f;
        f.force_x = pick_force();
        f.force_y = pick_force();
        f.force_z = pick_force();
        return f;
    endfunction

    // mostly plausible physics, sometimes full range or rail values per register
    function automatic void pick_config();
        bit wild;
        wild = ($urandom_range(3) == 0);
        cfg_shadow[REG_TIME_STEP]    = word_t'($urandom_range(6554, 1));
        cfg_shadow[REG_INVERSE_MASS] = word_t'($urandom_range(1 << 20));
        cfg_shadow[REG_DAMPING]      = word_t'($urandom_range(1 << 20));
        cfg_shadow[REG_STIFFNESS]    = word_t'($urandom_range(1 << 22));
        cfg_shadow[REG_FORCE_GAIN]   = word_t'($urandom_range(1 << 19)) - word_t'(1 << 18);
        for (int i = REG_AXIS_X; i <= REG_AXIS_Z; i++)
            cfg_shadow[i] = word_t'($urandom_range(1 << 18)) - word_t'(1 << 17);
        for (int i = 0; i < 8; i++)
        begin
            if (wild)
            begin
                case ($urandom_range(2))
                    1:       cfg_shadow[i] = word_t'($urandom);
                    2:       cfg_shadow[i] = rail_word();
                    default: ;
                endcase
            end
            // top bit of the unsigned registers should be ignored
            if (i <= REG_STIFFNESS)
                cfg_shadow[i][DATA_WIDTH-1] = 1'($urandom_range(1));
        end
    endfunction

    // ---------------- drivers ----------------

    task automatic program_all();
        for (int i = 0; i < 8; i++)
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= cfg_shadow[i];
            @(posedge clk);
            apply_register(cfg_index_t'(i), cfg_shadow[i]);
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_force(input in_item_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_steps.push_back(advance_spring(item));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (holdoff_done < holdoff_len)
        begin
            out_stall    <= 1'b1;
            holdoff_done <= holdoff_done + 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input word_t want, input word_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_steps.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none, actual %p",
                         $time, out_data);
                mismatches++;
            end
            else
            begin
                want = pending_steps.pop_front();
                check_field("new_position", want.new_position, out_data.new_position);
                check_field("new_velocity", want.new_velocity, out_data.new_velocity);
                check_field("disp_x", want.disp_x, out_data.disp_x);
                check_field("disp_y", want.disp_y, out_data.disp_y);
                check_field("disp_z", want.disp_z, out_data.disp_z);
                check_field("axial_force", want.axial_force, out_data.axial_force);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_default_config();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        send_force(in_item_t'{32'sd0, 32'sd0, 32'sd0});
        send_force(in_item_t'{32'sd65536, 32'sd0, 32'sd0});
        send_force(in_item_t'{WORD_MAX, WORD_MAX, WORD_MAX});
        send_force(in_item_t'{WORD_MIN, WORD_MIN, WORD_MIN});
        send_force(in_item_t'{WORD_MIN, WORD_MAX, -32'sd1});
        send_force(in_item_t'{32'sd1, -32'sd1, WORD_MIN});
        wait_idle();
    endtask

    task automatic try_setting(input cfg_index_t idx, input word_t v);
        cfg_shadow[idx] = v;
        program_all();
        send_force(in_item_t'{rail_word(), rail_word(), rail_word()});
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // zero step must leave position and velocity untouched
        try_setting(REG_TIME_STEP, '0);
        try_setting(REG_TIME_STEP, WORD_MAX);
        try_setting(REG_TIME_STEP, 32'sd1);
        try_setting(REG_INVERSE_MASS, '0);
        try_setting(REG_INVERSE_MASS, WORD_MAX);
        try_setting(REG_DAMPING, WORD_MAX);
        try_setting(REG_STIFFNESS, WORD_MAX);
        try_setting(REG_FORCE_GAIN, WORD_MIN);
        try_setting(REG_FORCE_GAIN, WORD_MAX);
        try_setting(REG_AXIS_X, WORD_MIN);
        try_setting(REG_AXIS_Y, WORD_MAX);
        try_setting(REG_AXIS_Z, WORD_MIN);
        // bit above the register width set
        try_setting(REG_TIME_STEP, word_t'(32'h8000_0001));
        try_setting(REG_DAMPING, WORD_MIN);
    endtask

    task automatic test_random_steps(input int gap_pct, input int stall_pct, input int count);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n += BLOCK_ITEMS)
        begin
            pick_config();
            program_all();
            for (int j = 0; j < BLOCK_ITEMS; j++)
                send_force(random_force());
            wait_idle();
        end
    endtask

    // output held off while requests keep coming, so the input side backs up
    task automatic test_output_holdoff();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        pick_config();
        program_all();
        @(posedge clk);
        holdoff_len = holdoff_len + HOLDOFF_CYCLES;
        for (int j = 0; j < 20; j++)
            send_force(random_force());
        wait_idle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_TIME_STEP;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_shadow[REG_TIME_STEP]    = 32'sd655;
        cfg_shadow[REG_INVERSE_MASS] = 32'sd65536;
        cfg_shadow[REG_DAMPING]      = 32'sd0;
        cfg_shadow[REG_STIFFNESS]    = 32'sd0;
        cfg_shadow[REG_FORCE_GAIN]   = 32'sd65536;
        cfg_shadow[REG_AXIS_X]       = 32'sd65536;
        cfg_shadow[REG_AXIS_Y]       = 32'sd0;
        cfg_shadow[REG_AXIS_Z]       = 32'sd0;
        for (int i = 0; i < 8; i++)
            apply_register(cfg_index_t'(i), cfg_shadow[i]);
        spring_pos = 0;
        spring_vel = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_register_extremes();
        test_random_steps(19, 88, 650);
        test_random_steps(88, 19, 650);
        test_output_holdoff();
        test_random_steps(0, 0, 650);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_steps.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
